@@ rtl/core/fbrp_pkg.sv @@
`default_nettype none

package fbrp_pkg;

    localparam int MAX_KMER = 32;
    localparam int HELD_DEPTH = MAX_KMER - 1;

    localparam logic [7:0] ASCII_AT = 8'h40;
    localparam logic [7:0] ASCII_LF = 8'h0A;

    localparam logic [5:0] KMER_RESET = 6'd31;
    localparam logic [5:0] RUN_MAX = 6'd63;
    localparam logic [1:0] SEQ_LINE = 2'd1;

    typedef enum logic [1:0] {
        KIND_BASE = 2'd0,
        KIND_SEP  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CODE_A = 2'd0,
        CODE_C = 2'd1,
        CODE_T = 2'd2,
        CODE_G = 2'd3
    } base_code_t;

    typedef enum logic {
        ST_IDLE,
        ST_FLUSH
    } state_t;

    // Shared controls that every cell of the hold chain sees.
    typedef struct packed {
        logic       shift;
        logic [1:0] wr_code;
    } cell_ctl_t;

    typedef struct packed {
        logic       is_base;
        base_code_t code;
    } base_dec_t;

    function automatic base_dec_t decode_base(input logic [7:0] b);
        base_dec_t d;
        d.is_base = 1'b1;
        d.code    = CODE_A;
        unique case (b)
            8'h41, 8'h61: d.code = CODE_A;
            8'h43, 8'h63: d.code = CODE_C;
            8'h54, 8'h74: d.code = CODE_T;
            8'h47, 8'h67: d.code = CODE_G;
            default:      d.is_base = 1'b0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/fbrp_cell.sv @@
`default_nettype none

module fbrp_cell (
    input  wire logic              clk,
    input  wire fbrp_pkg::cell_ctl_t ctl,
    input  wire logic              load,
    input  wire logic [1:0]        shift_in,
    output logic [1:0]             code
);
    import fbrp_pkg::*;

    logic [1:0] code_reg;
    logic [1:0] code_next;

    // A write from the front end wins; otherwise the chain moves one place
    // toward the head during a flush.
    always_comb
    begin
        code_next = code_reg;
        if (load)
        begin
            code_next = ctl.wr_code;
        end
        else if (ctl.shift)
        begin
            code_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    assign code = code_reg;

endmodule

`default_nettype wire

@@ rtl/core/fastq_base_run_packer.sv @@
// FASTQ base run packer.
// Input: s_axis_* carries one byte of FASTQ text per transaction. Output:
// m_axis_* carries one result per transaction: a 2-bit base code, a run
// separator or a single format error; tlast marks the final result caused
// by one input byte. cfg_we/cfg_wdata write kmer_length (reset 31) and
// may be used only while the block is idle.
// An accepted byte's first result is registered and leaves in the cycle
// after it. With a ready receiver the block takes one byte per cycle. The
// byte that makes a held run reach kmer_length is the exception: the block
// enters its flush state; the held codes then leave one per cycle while
// m_axis_tready is high, head of the chain first, and its own code last.
// s_axis_tready stays low until the flush ends. Held codes sit in a row of
// 31 cells that shift toward the head while they are flushed.
// A single output register separates the two sides; while it is full and
// m_axis_tready is low, no byte is accepted and the result holds.
// Reset (rst_n low, asynchronous) returns the block to the header line with
// no open run and no first byte seen. If the first byte is not '@' one
// error result is sent and every later byte is accepted and ignored.
`default_nettype none

module fastq_base_run_packer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [5:0] cfg_wdata,      // kmer_length
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] byte_value
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [1:0] item_kind, [3:2] base_code, [7:4] zero
    output logic            m_axis_tlast    // last_of_burst
);
    import fbrp_pkg::*;

    state_t     state_reg, state_next;
    logic [5:0] kmer_reg;
    logic [1:0] line_reg, line_next;
    logic [5:0] run_len_reg, run_len_next;
    logic       seen_reg, seen_next;
    logic       failed_reg, failed_next;
    logic       streaming_reg, streaming_next;
    logic [5:0] flush_cnt_reg, flush_cnt_next;
    logic [1:0] pend_code_reg, pend_code_next;

    logic       out_valid_reg, out_valid_next;
    kind_t      out_kind_reg, out_kind_next;
    logic [1:0] out_code_reg, out_code_next;
    logic       out_last_reg, out_last_next;

    logic       out_free;
    logic       in_fire;
    logic [5:0] k_eff;
    logic [5:0] new_len;
    base_dec_t  dec;
    logic       go_flush;
    logic       cell_wr;

    cell_ctl_t  cell_ctl;
    logic [1:0] chain [HELD_DEPTH];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign dec     = decode_base(s_axis_tdata);
    assign new_len = (run_len_reg < RUN_MAX) ? run_len_reg + 6'd1 : RUN_MAX;

    always_comb
    begin
        if (kmer_reg == 6'd0)
        begin
            k_eff = 6'd1;
        end
        else if (kmer_reg > 6'(MAX_KMER))
        begin
            k_eff = 6'(MAX_KMER);
        end
        else
        begin
            k_eff = kmer_reg;
        end
    end

    // Classification of the accepted byte, valid only with in_fire.
    logic on_seq;
    logic bad_first;
    assign bad_first = !failed_reg && !seen_reg && (s_axis_tdata != ASCII_AT);
    assign on_seq    = !failed_reg && !bad_first && (line_reg == SEQ_LINE);
    assign go_flush  = in_fire && on_seq && dec.is_base && !streaming_reg
                       && (new_len >= k_eff) && (run_len_reg != 6'd0);
    assign cell_wr   = in_fire && on_seq && dec.is_base && !streaming_reg
                       && (new_len < k_eff);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (go_flush)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (out_free && (flush_cnt_reg == 6'd0))
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        line_next      = line_reg;
        run_len_next   = run_len_reg;
        seen_next      = seen_reg;
        failed_next    = failed_reg;
        streaming_next = streaming_reg;
        flush_cnt_next = flush_cnt_reg;
        pend_code_next = pend_code_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_kind_next  = out_kind_reg;
        out_code_next  = out_code_reg;
        out_last_next  = out_last_reg;
        cell_ctl.shift   = 1'b0;
        cell_ctl.wr_code = dec.code;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && !failed_reg)
                begin
                    seen_next = 1'b1;
                    if (bad_first)
                    begin
                        failed_next    = 1'b1;
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_ERR;
                        out_code_next  = 2'd0;
                        out_last_next  = 1'b1;
                    end
                    else
                    begin
                        if (on_seq)
                        begin
                            if (dec.is_base)
                            begin
                                run_len_next = new_len;
                                if (streaming_reg || (new_len >= k_eff))
                                begin
                                    streaming_next = 1'b1;
                                    if (go_flush)
                                    begin
                                        flush_cnt_next = run_len_reg;
                                        pend_code_next = dec.code;
                                    end
                                    else
                                    begin
                                        out_valid_next = 1'b1;
                                        out_kind_next  = KIND_BASE;
                                        out_code_next  = dec.code;
                                        out_last_next  = 1'b1;
                                    end
                                end
                            end
                            else
                            begin
                                if (streaming_reg)
                                begin
                                    out_valid_next = 1'b1;
                                    out_kind_next  = KIND_SEP;
                                    out_code_next  = 2'd0;
                                    out_last_next  = 1'b1;
                                end
                                run_len_next   = 6'd0;
                                streaming_next = 1'b0;
                            end
                        end
                        if (s_axis_tdata == ASCII_LF)
                        begin
                            line_next = line_reg + 2'd1;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_BASE;
                    if (flush_cnt_reg != 6'd0)
                    begin
                        out_code_next  = chain[0];
                        out_last_next  = 1'b0;
                        cell_ctl.shift = 1'b1;
                        flush_cnt_next = flush_cnt_reg - 6'd1;
                    end
                    else
                    begin
                        out_code_next = pend_code_reg;
                        out_last_next = 1'b1;
                    end
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < HELD_DEPTH; gi++)
        begin : g_cell
            logic [1:0] shift_src;
            if (gi == HELD_DEPTH - 1)
            begin : g_tail
                assign shift_src = 2'd0;
            end
            else
            begin : g_mid
                assign shift_src = chain[gi + 1];
            end
            fbrp_cell u_cell (
                .clk      (clk),
                .ctl      (cell_ctl),
                .load     (cell_wr && (run_len_reg == 6'(gi))),
                .shift_in (shift_src),
                .code     (chain[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kmer_reg      <= KMER_RESET;
            line_reg      <= 2'd0;
            run_len_reg   <= 6'd0;
            seen_reg      <= 1'b0;
            failed_reg    <= 1'b0;
            streaming_reg <= 1'b0;
            flush_cnt_reg <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                kmer_reg <= cfg_wdata;
            end
            line_reg      <= line_next;
            run_len_reg   <= run_len_next;
            seen_reg      <= seen_next;
            failed_reg    <= failed_next;
            streaming_reg <= streaming_next;
            flush_cnt_reg <= flush_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_code_reg <= pend_code_next;
        out_kind_reg  <= out_kind_next;
        out_code_reg  <= out_code_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_code_reg, out_kind_reg};
    assign m_axis_tlast  = out_last_reg;

    a_flush_bound: assert property (@(posedge clk) disable iff (!rst_n)
        flush_cnt_reg <= 6'(HELD_DEPTH))
        else $error("flush count exceeds hold chain depth");

    a_flush_streams: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> streaming_reg && !failed_reg)
        else $error("flush without a streaming run");

    a_flush_start: assert property (@(posedge clk) disable iff (!rst_n)
        go_flush |=> (state_reg == ST_FLUSH) && (flush_cnt_reg != 6'd0))
        else $error("flush did not start with held codes");

endmodule

`default_nettype wire
